/* rtl/cmv_pkg.sv */
`timescale 1ns / 1ps

package cmv_pkg;

  localparam int NUM_CORNERS = 8;
  localparam int NUM_EDGES   = 12;
  localparam int NUM_FACES   = 6;

  localparam logic MODE_MOVE = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [4:0] MOVE_PRIME_BASE  = 5'd6;
  localparam logic [4:0] MOVE_DOUBLE_BASE = 5'd12;
  localparam logic [4:0] MOVE_NONE_BASE   = 5'd18;

  localparam logic [1:0] REPS_CW     = 2'd1;
  localparam logic [1:0] REPS_DOUBLE = 2'd2;
  localparam logic [1:0] REPS_PRIME  = 2'd3;

  // slot order: corners URF UFL ULB UBR DFR DLF DBL DRB,
  // edges UR UF UL UB DR DF DL DB FR FL BL BR
  localparam logic [2:0] CORNER_CYCLE [NUM_FACES][4] = '{
    '{3'd0, 3'd3, 3'd2, 3'd1}, '{3'd4, 3'd5, 3'd6, 3'd7}, '{3'd1, 3'd5, 3'd6, 3'd2},
    '{3'd0, 3'd3, 3'd7, 3'd4}, '{3'd0, 3'd1, 3'd5, 3'd4}, '{3'd3, 3'd2, 3'd6, 3'd7}
  };
  localparam logic [1:0] CORNER_DELTA [NUM_FACES][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd2, 2'd1, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd1, 2'd2}, '{2'd2, 2'd1, 2'd2, 2'd1}
  };
  localparam logic [3:0] EDGE_CYCLE [NUM_FACES][4] = '{
    '{4'd0, 4'd3, 4'd2, 4'd1},  '{4'd4, 4'd5, 4'd6, 4'd7}, '{4'd2, 4'd9, 4'd6, 4'd10},
    '{4'd0, 4'd11, 4'd4, 4'd8}, '{4'd1, 4'd9, 4'd5, 4'd8}, '{4'd3, 4'd10, 4'd7, 4'd11}
  };
  localparam logic EDGE_DELTA [NUM_FACES][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b1, 1'b1}
  };

  // first member in the high bits, so cp sits at bit 0
  typedef struct packed {
    logic [NUM_EDGES-1:0]        ef;
    logic [NUM_EDGES-1:0][3:0]   ep;
    logic [NUM_CORNERS-1:0][1:0] ct;
    logic [NUM_CORNERS-1:0][2:0] cp;
  } cmv_state_t;

  typedef struct packed {
    logic       mode;
    logic [4:0] code;
    cmv_state_t load;
  } cmv_item_t;

  typedef struct packed {
    logic       turn;
    logic [2:0] face;
    logic [1:0] reps;
  } cmv_move_t;

  localparam cmv_state_t SOLVED = '{
    ef: '0,
    ep: 48'hBA9876543210,
    ct: '0,
    cp: 24'hFAC688
  };

  function automatic cmv_move_t cmv_decode(input logic [4:0] code);
    cmv_move_t m;
    m = '{turn: 1'b1, face: 3'd0, reps: REPS_CW};
    if (code < MOVE_PRIME_BASE) begin
      m.face = code[2:0];
    end else if (code < MOVE_DOUBLE_BASE) begin
      m.face = 3'(code - MOVE_PRIME_BASE);
      m.reps = REPS_PRIME;
    end else if (code < MOVE_NONE_BASE) begin
      m.face = 3'(code - MOVE_DOUBLE_BASE);
      m.reps = REPS_DOUBLE;
    end else begin
      m.turn = 1'b0;
    end
    return m;
  endfunction

  // (a + b) mod 3, a twist of 3 acts as 0
  function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'd3) s = s - 3'd3;
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

endpackage

/* rtl/cmv_turn.sv */
`timescale 1ns / 1ps

module cmv_turn import cmv_pkg::*; (
  input  cmv_state_t cur,
  input  cmv_item_t  item,
  output cmv_state_t nxt
);

  cmv_move_t mv;

  assign mv = cmv_decode(item.code);

  always_comb begin : p_turn
    logic [2:0] cs, cd;
    logic [3:0] es, ed;
    logic [1:0] tw;
    logic       fl;
    cs  = '0;
    cd  = '0;
    es  = '0;
    ed  = '0;
    tw  = '0;
    fl  = 1'b0;
    nxt = cur;
    if (item.mode == MODE_LOAD) begin
      nxt = item.load;
    end else if (mv.turn) begin
      for (int k = 0; k < 4; k++) begin
        cs = CORNER_CYCLE[mv.face][k];
        cd = CORNER_CYCLE[mv.face][2'(k) + mv.reps];
        es = EDGE_CYCLE[mv.face][k];
        ed = EDGE_CYCLE[mv.face][2'(k) + mv.reps];
        tw = 2'd0;
        fl = cur.ef[es];
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < mv.reps) begin
            tw = mod3_add(tw, CORNER_DELTA[mv.face][2'(k) + 2'(j)]);
            fl = fl ^ EDGE_DELTA[mv.face][2'(k) + 2'(j)];
          end
        end
        nxt.cp[cd] = cur.cp[cs];
        nxt.ct[cd] = mod3_add(cur.ct[cs], tw);
        nxt.ep[ed] = cur.ep[es];
        nxt.ef[ed] = fl;
      end
    end
  end

endmodule

/* rtl/cmv_out_q.sv */
`timescale 1ns / 1ps

module cmv_out_q import cmv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmv_state_t push_data,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output cmv_state_t out_data
);

  logic       main_valid;
  logic       skid_valid;
  cmv_state_t main_data;
  cmv_state_t skid_data;
  logic       pop;

  assign pop       = main_valid && out_ready;
  assign room      = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (push && main_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      if (!main_valid || pop) begin
        main_valid <= skid_valid || push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end
    if (!skid_valid && push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

/* rtl/cube_cubie_move_apply_top.sv */
`timescale 1ns / 1ps

// Cubie-level 3x3 cube move engine. Each input beat either loads a packed cube
// state (tuser high) or applies move_code (tuser low: 0-5 U,D,L,R,F,B, 6-11
// primes, 12-17 doubles, 18-31 no change); every input beat returns one output
// beat with the packed state after it. Reset gives the solved cube. One beat is
// accepted per clock while the output stage has room; the input register feeds
// the single-pass turn logic, whose result goes to the state register and the
// two-entry output stage, which keeps input flowing while a result waits.

module cube_cubie_move_apply_top import cmv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // move_code[4:0], load_corner_pieces[28:5], load_corner_twists[44:29],
  // load_edge_pieces[92:45], load_edge_flips[104:93], zero pad
  input  logic [111:0] s_tdata,
  // mode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // corner_pieces[23:0], corner_twists[39:24], edge_pieces[87:40],
  // edge_flips[99:88], zero pad
  output logic [103:0] m_tdata
);

  logic       in_valid;
  cmv_item_t  in_item;
  cmv_state_t state;
  cmv_state_t state_next;
  cmv_state_t out_state;
  logic       room;
  logic       adv;

  assign adv      = in_valid && room;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.mode <= s_tuser;
      in_item.code <= s_tdata[4:0];
      in_item.load <= s_tdata[104:5];
    end
  end

  cmv_turn u_turn (
    .cur  (state),
    .item (in_item),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SOLVED;
    end else if (adv) begin
      state <= state_next;
    end
  end

  cmv_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (adv),
    .push_data (state_next),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_state)
  );

  assign m_tdata = {4'b0, out_state};

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(state))
    else $error("state changed without an accepted beat");

  a_load: assert property (@(posedge clk) disable iff (rst)
    adv && in_item.mode == MODE_LOAD |=> state == $past(in_item.load))
    else $error("load did not replace the state");

  a_nop: assert property (@(posedge clk) disable iff (rst)
    adv && in_item.mode == MODE_MOVE && in_item.code >= MOVE_NONE_BASE
    |=> $stable(state))
    else $error("unused move code changed the state");

  a_full: assert property (@(posedge clk) disable iff (rst)
    !room |-> m_tvalid)
    else $error("output stage full but not presenting a beat");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cmv_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         DRAIN_CYCLES  = 20;
  localparam logic [4:0] MOVE_CODE_MAX = 5'd31;
  localparam int         FACE_L        = 2;

  // clockwise turn: piece in ring entry k goes to entry k+1
  localparam int CORNER_RING [6][4] = '{
    '{0, 3, 2, 1}, '{4, 5, 6, 7}, '{1, 5, 6, 2},
    '{0, 3, 7, 4}, '{0, 1, 5, 4}, '{3, 2, 6, 7}
  };
  localparam int CORNER_SPIN [6][4] = '{
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{2, 1, 2, 1},
    '{1, 2, 1, 2}, '{1, 2, 1, 2}, '{2, 1, 2, 1}
  };
  localparam int EDGE_RING [6][4] = '{
    '{0, 3, 2, 1}, '{4, 5, 6, 7}, '{2, 9, 6, 10},
    '{0, 11, 4, 8}, '{1, 9, 5, 8}, '{3, 10, 7, 11}
  };
  localparam int EDGE_TOGGLE [6][4] = '{
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
    '{0, 0, 0, 0}, '{1, 1, 1, 1}, '{1, 1, 1, 1}
  };

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;

  cmv_state_t cube_model;
  cmv_state_t cube_states_due[$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         tx_gaps_on;
  bit         rx_stalls_on;
  bit         hold_off_req;

  cube_cubie_move_apply_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic cmv_state_t solved_cube();
    cmv_state_t c;
    int i;
    c = '0;
    for (i = 0; i < NUM_CORNERS; i++) c.cp[i] = 3'(i);
    for (i = 0; i < NUM_EDGES; i++) c.ep[i] = 4'(i);
    return c;
  endfunction

  function automatic cmv_state_t quarter_turn(input cmv_state_t c, input int face);
    cmv_state_t n;
    int k, src, dst;
    n = c;
    for (k = 0; k < 4; k++) begin
      src = CORNER_RING[face][k];
      dst = CORNER_RING[face][(k + 1) % 4];
      n.cp[dst] = c.cp[src];
      n.ct[dst] = 2'((int'(c.ct[src]) + CORNER_SPIN[face][k]) % 3);
      src = EDGE_RING[face][k];
      dst = EDGE_RING[face][(k + 1) % 4];
      n.ep[dst] = c.ep[src];
      n.ef[dst] = c.ef[src] ^ 1'(EDGE_TOGGLE[face][k]);
    end
    return n;
  endfunction

  function automatic cmv_state_t cube_after(input cmv_state_t c, input logic mode,
                                            input logic [4:0] code, input cmv_state_t ld);
    int face, turns;
    if (mode == MODE_LOAD) return ld;
    if (code < MOVE_NONE_BASE) begin
      face  = int'(code) % 6;
      turns = (code < MOVE_PRIME_BASE) ? 1 : (code < MOVE_DOUBLE_BASE) ? 3 : 2;
      repeat (turns) c = quarter_turn(c, face);
    end
    return c;
  endfunction

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cmv_state_t random_cube();
    cmv_state_t c;
    c.cp = 24'($urandom);
    c.ct = 16'($urandom);
    c.ep = {16'($urandom), 32'($urandom)};
    c.ef = 12'($urandom);
    return c;
  endfunction

  // valid stays high between back-to-back beats; it drops only before a gap
  task automatic send_beat(input logic mode, input logic [4:0] code, input cmv_state_t ld);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, ld.ef, ld.ep, ld.ct, ld.cp, code};
    do @(posedge clk); while (!s_tready);
    cube_model = cube_after(cube_model, mode, code, ld);
    cube_states_due.push_back(cube_model);
  endtask

  task automatic send_move(input logic [4:0] code);
    send_beat(MODE_MOVE, code, random_cube());
  endtask

  task automatic send_random_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      send_beat(MODE_LOAD, 5'($urandom), random_cube());
    else if (r < 15)
      send_move(5'($urandom_range(MOVE_NONE_BASE, MOVE_CODE_MAX)));
    else
      send_move(5'($urandom_range(0, MOVE_NONE_BASE - 1)));
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (pick_gap(rx_stalls_on) > 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap(1'b1) + 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cmv_state_t exp_c, act_c;
    if (!rst && m_tvalid && m_tready) begin
      act_c = m_tdata[99:0];
      if (cube_states_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none got %h", $time, m_tdata);
        mismatches++;
      end else begin
        exp_c = cube_states_due.pop_front();
        check_field("corner_pieces", 48'(exp_c.cp), 48'(act_c.cp));
        check_field("corner_twists", 48'(exp_c.ct), 48'(act_c.ct));
        check_field("edge_pieces", 48'(exp_c.ep), 48'(act_c.ep));
        check_field("edge_flips", 48'(exp_c.ef), 48'(act_c.ef));
        check_field("pad", 48'(m_tdata[103:100]), 48'd0);
      end
    end
  end

  task automatic test_unused_codes();
    send_move(MOVE_NONE_BASE);
    send_move(MOVE_CODE_MAX);
  endtask

  task automatic test_every_turn();
    int code;
    for (code = 0; code < MOVE_NONE_BASE; code++) send_move(5'(code));
  endtask

  task automatic test_odd_loads();
    cmv_state_t c;
    c = '1;
    // twist 3 on every corner and edge pieces out of range
    send_beat(MODE_LOAD, 5'd0, c);
    send_move(5'(FACE_L));
    send_beat(MODE_LOAD, MOVE_CODE_MAX, '0);
    send_beat(MODE_LOAD, 5'd3, solved_cube());
  endtask

  task automatic test_random_traffic(input int count, input bit idle);
    tx_gaps_on   = idle;
    rx_stalls_on = idle;
    repeat (count) send_random_beat();
  endtask

  task automatic test_output_hold_off();
    tx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_random_beat();
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = MODE_MOVE;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    hold_off_req = 1'b0;
    cube_model   = solved_cube();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unused_codes();
    test_every_turn();
    test_odd_loads();
    test_random_traffic(300, 1'b1);
    test_random_traffic(150, 1'b0);
    test_output_hold_off();
    test_random_traffic(260, 1'b1);

    s_tvalid <= 1'b0;
    while (cube_states_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/cmv_pkg.sv
rtl/cmv_turn.sv
rtl/cmv_out_q.sv
rtl/cube_cubie_move_apply_top.sv
dv/testbench.sv
